FILE: rtl/core/dbdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdf_pkg
// Shared types and constants of the detection box decode filter.
// ----------------------------------------------------------------------------
package dbdf_pkg;

  localparam int MAX_CLASSES  = 80;
  localparam int BOX_FIELDS   = 5;
  localparam int OBJ_POS      = 4;
  localparam int FRAC_CORNER  = 33;
  localparam int SCORE_MAX    = 65536;

  localparam int ELEM_W   = 32;
  localparam int POS_W    = 7;
  localparam int THR_W    = 17;
  localparam int SCALE_W  = 24;
  localparam int PIX_W    = 16;
  localparam int SCORE_W  = 17;
  localparam int CLASS_W  = 7;
  localparam int ROW_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // corner differences and their scaled products
  localparam int SUM_W  = ELEM_W + 2;
  localparam int PROD_W = SUM_W + SCALE_W + 1;
  localparam int CONF_W = 2 * ELEM_W;

  localparam int OUT_DATA_W = 4 * PIX_W + SCORE_W + CLASS_W + ROW_W;

  localparam logic [POS_W-1:0]   RST_CLASS_COUNT = 7'd80;
  localparam logic [THR_W-1:0]   RST_OBJ_THR     = 17'd16384;
  localparam logic [THR_W-1:0]   RST_CONF_THR    = 17'd16384;
  localparam logic [SCALE_W-1:0] RST_SCALE       = 24'd65536;
  localparam logic [PIX_W-1:0]   RST_IMAGE_SIZE  = 16'd640;
  localparam logic [ROW_W-1:0]   RST_ROWS        = 16'd25200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT = 3'd0,
    REG_OBJ_THR     = 3'd1,
    REG_CONF_THR    = 3'd2,
    REG_SCALE_H     = 3'd3,
    REG_SCALE_V     = 3'd4,
    REG_IMAGE_W     = 3'd5,
    REG_IMAGE_H     = 3'd6,
    REG_ROWS        = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] center_x;
    logic signed [ELEM_W-1:0] center_y;
    logic signed [ELEM_W-1:0] box_width;
    logic signed [ELEM_W-1:0] box_height;
    logic signed [ELEM_W-1:0] objectness;
    logic signed [ELEM_W-1:0] best_score;
    logic [CLASS_W-1:0]       best_class;
    logic [ROW_W-1:0]         row_number;
  } row_rec_t;

  typedef struct packed {
    logic [THR_W-1:0]   objectness_threshold;
    logic [THR_W-1:0]   confidence_threshold;
    logic [SCALE_W-1:0] scale_horizontal;
    logic [SCALE_W-1:0] scale_vertical;
    logic [PIX_W-1:0]   image_width;
    logic [PIX_W-1:0]   image_height;
  } box_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   left_edge;
    logic [PIX_W-1:0]   top_edge;
    logic [PIX_W-1:0]   right_edge;
    logic [PIX_W-1:0]   bottom_edge;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_index;
    logic [ROW_W-1:0]   row_number;
  } box_out_t;

endpackage

FILE: rtl/core/dbdf_row_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdf_row_accum
// Collects the box fields of a row, keeps the running class argmax and
// hands a finished row record to the box stages.
// ----------------------------------------------------------------------------
module dbdf_row_accum import dbdf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     elem_fire,
  input  logic signed [ELEM_W-1:0] elem,
  input  logic [POS_W-1:0]         class_count,
  input  logic [ROW_W-1:0]         rows_per_frame,
  output logic                     rec_valid,
  output row_rec_t                 rec
);

  logic [POS_W-1:0]         element_position;
  logic [POS_W-1:0]         element_position_next;
  logic [ROW_W-1:0]         row_counter;
  logic [ROW_W:0]           row_inc;
  logic signed [ELEM_W-1:0] center_x, center_y, box_width, box_height, objectness;
  logic signed [ELEM_W-1:0] best_score, best_score_next;
  logic [CLASS_W-1:0]       best_class, best_class_next;
  logic [POS_W-1:0]         last_pos;
  logic                     row_end;

  always_comb begin
    if (class_count == '0) begin
      last_pos = POS_W'(OBJ_POS + 1);
    end else if (class_count > POS_W'(MAX_CLASSES)) begin
      last_pos = POS_W'(OBJ_POS + MAX_CLASSES);
    end else begin
      last_pos = class_count + POS_W'(OBJ_POS);
    end
  end

  assign row_end = (element_position >= last_pos);
  assign element_position_next = row_end ? '0 : element_position + 1'b1;
  assign row_inc = {1'b0, row_counter} + 1'b1;

  // first score of a row seeds the argmax, later ones win only when larger
  always_comb begin
    best_score_next = best_score;
    best_class_next = best_class;
    if (element_position == POS_W'(BOX_FIELDS)) begin
      best_score_next = elem;
      best_class_next = '0;
    end else if (element_position > POS_W'(BOX_FIELDS) && elem > best_score) begin
      best_score_next = elem;
      best_class_next = CLASS_W'(element_position - POS_W'(BOX_FIELDS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_position <= '0;
      row_counter      <= '0;
      center_x         <= '0;
      center_y         <= '0;
      box_width        <= '0;
      box_height       <= '0;
      objectness       <= '0;
      best_score       <= '0;
      best_class       <= '0;
    end else if (elem_fire) begin
      element_position <= element_position_next;
      best_score       <= best_score_next;
      best_class       <= best_class_next;
      case (element_position)
        POS_W'(0): center_x   <= elem;
        POS_W'(1): center_y   <= elem;
        POS_W'(2): box_width  <= elem;
        POS_W'(3): box_height <= elem;
        POS_W'(4): objectness <= elem;
        default: ;
      endcase
      if (row_end) begin
        row_counter <= (row_inc >= {1'b0, rows_per_frame}) ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (advance) begin
      rec_valid <= elem_fire && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_fire && row_end) begin
      rec.center_x   <= center_x;
      rec.center_y   <= center_y;
      rec.box_width  <= box_width;
      rec.box_height <= box_height;
      rec.objectness <= objectness;
      rec.best_score <= best_score_next;
      rec.best_class <= best_class_next;
      rec.row_number <= row_counter;
    end
  end

endmodule

FILE: rtl/core/dbdf_box_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdf_box_calc
// Thresholds, corner scaling, clamping and the result register.
// Stage 1: corner sums, objectness test, confidence product.
// Stage 2: scaled corners, confidence test, score saturation.
// Stage 3: clamp, empty box test, result register.
// ----------------------------------------------------------------------------
module dbdf_box_calc import dbdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  box_cfg_t cfg,
  input  logic     rec_valid,
  input  row_rec_t rec,
  output logic     out_valid,
  output box_out_t out_box
);

  // stage 1
  logic signed [SUM_W-1:0]  dx1_c, dx2_c, dy1_c, dy2_c;
  logic signed [SUM_W-1:0]  s1_dx1, s1_dx2, s1_dy1, s1_dy2;
  logic signed [CONF_W-1:0] conf_c, s1_conf;
  logic                     obj_ok_c, s1_valid;
  logic [CLASS_W-1:0]       s1_class;
  logic [ROW_W-1:0]         s1_row;

  assign dx1_c = {rec.center_x[ELEM_W-1], rec.center_x, 1'b0}
               - {{2{rec.box_width[ELEM_W-1]}}, rec.box_width};
  assign dx2_c = {rec.center_x[ELEM_W-1], rec.center_x, 1'b0}
               + {{2{rec.box_width[ELEM_W-1]}}, rec.box_width};
  assign dy1_c = {rec.center_y[ELEM_W-1], rec.center_y, 1'b0}
               - {{2{rec.box_height[ELEM_W-1]}}, rec.box_height};
  assign dy2_c = {rec.center_y[ELEM_W-1], rec.center_y, 1'b0}
               + {{2{rec.box_height[ELEM_W-1]}}, rec.box_height};
  assign obj_ok_c = $signed({rec.objectness[ELEM_W-1], rec.objectness})
                 >= $signed({{(ELEM_W+1-THR_W){1'b0}}, cfg.objectness_threshold});
  assign conf_c = rec.objectness * rec.best_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= rec_valid && obj_ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dx1   <= dx1_c;
      s1_dx2   <= dx2_c;
      s1_dy1   <= dy1_c;
      s1_dy2   <= dy2_c;
      s1_conf  <= conf_c;
      s1_class <= rec.best_class;
      s1_row   <= rec.row_number;
    end
  end

  // stage 2
  logic signed [PROD_W-1:0] x1_c, x2_c, y1_c, y2_c;
  logic signed [PROD_W-1:0] s2_x1, s2_x2, s2_y1, s2_y2;
  logic                     conf_ok_c, sat_c, s2_valid;
  logic [SCORE_W-1:0]       score_c, s2_score;
  logic [CLASS_W-1:0]       s2_class;
  logic [ROW_W-1:0]         s2_row;

  assign x1_c = s1_dx1 * $signed({1'b0, cfg.scale_horizontal});
  assign x2_c = s1_dx2 * $signed({1'b0, cfg.scale_horizontal});
  assign y1_c = s1_dy1 * $signed({1'b0, cfg.scale_vertical});
  assign y2_c = s1_dy2 * $signed({1'b0, cfg.scale_vertical});
  assign conf_ok_c = s1_conf
                  >= $signed({{(CONF_W-THR_W-16){1'b0}}, cfg.confidence_threshold, 16'b0});
  assign sat_c = $signed(s1_conf[CONF_W-1:16]) > $signed((CONF_W-16)'(SCORE_MAX));
  assign score_c = sat_c ? SCORE_W'(SCORE_MAX) : s1_conf[16 +: SCORE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && conf_ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_x1    <= x1_c;
      s2_x2    <= x2_c;
      s2_y1    <= y1_c;
      s2_y2    <= y2_c;
      s2_score <= score_c;
      s2_class <= s1_class;
      s2_row   <= s1_row;
    end
  end

  // stage 3
  logic signed [PROD_W-1:0] xmax, ymax, x1c, x2c, y1c, y2c;
  logic                     box_ok;

  assign xmax = $signed({{(PROD_W-PIX_W-FRAC_CORNER){1'b0}}, cfg.image_width,
                         {FRAC_CORNER{1'b0}}});
  assign ymax = $signed({{(PROD_W-PIX_W-FRAC_CORNER){1'b0}}, cfg.image_height,
                         {FRAC_CORNER{1'b0}}});
  assign x1c = s2_x1[PROD_W-1] ? '0 : s2_x1;
  assign y1c = s2_y1[PROD_W-1] ? '0 : s2_y1;
  assign x2c = (s2_x2 > xmax) ? xmax : s2_x2;
  assign y2c = (s2_y2 > ymax) ? ymax : s2_y2;
  assign box_ok = (x2c > x1c) && (y2c > y1c);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid && box_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_box.left_edge   <= x1c[FRAC_CORNER +: PIX_W];
      out_box.top_edge    <= y1c[FRAC_CORNER +: PIX_W];
      out_box.right_edge  <= x2c[FRAC_CORNER +: PIX_W];
      out_box.bottom_edge <= y2c[FRAC_CORNER +: PIX_W];
      out_box.score       <= s2_score;
      out_box.class_index <= s2_class;
      out_box.row_number  <= s2_row;
    end
  end

endmodule

FILE: rtl/core/detection_box_decode_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_decode_filter_top
// Decodes detector rows into clamped, scaled boxes and keeps those that
// pass the objectness and confidence thresholds.
// ----------------------------------------------------------------------------
// channel   dir  fields (lowest bit first)
// s_*       in   tdata: element_value[31:0]
// m_*       out  tdata: left_edge, top_edge, right_edge, bottom_edge, score,
//                       class_index, row_number
// cfg_*     in   cfg_index selects the register, cfg_data carries the value
//
// One element is taken per cycle unless the output stalls. A kept row's result
// passes the row record register and the sum, multiply and clamp stages to
// m_tvalid. Reset loads the register defaults and clears the row position and
// row count. A held m_tvalid with m_tready low freezes all stages and s_tready.
// ----------------------------------------------------------------------------
module detection_box_decode_filter_top import dbdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ELEM_W-1:0]     s_tdata,   // element_value[31:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // left_edge[15:0], top_edge[31:16], right_edge[47:32], bottom_edge[63:48],
  // score[80:64], class_index[87:81], row_number[103:88]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [POS_W-1:0] class_count;
  logic [ROW_W-1:0] rows_per_frame;
  box_cfg_t         box_cfg;
  logic             advance;
  logic             elem_fire;
  logic             rec_valid;
  row_rec_t         rec;
  box_out_t         out_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count                  <= RST_CLASS_COUNT;
      box_cfg.objectness_threshold <= RST_OBJ_THR;
      box_cfg.confidence_threshold <= RST_CONF_THR;
      box_cfg.scale_horizontal     <= RST_SCALE;
      box_cfg.scale_vertical       <= RST_SCALE;
      box_cfg.image_width          <= RST_IMAGE_SIZE;
      box_cfg.image_height         <= RST_IMAGE_SIZE;
      rows_per_frame               <= RST_ROWS;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLASS_COUNT: class_count                  <= cfg_data[POS_W-1:0];
        REG_OBJ_THR:     box_cfg.objectness_threshold <= cfg_data[THR_W-1:0];
        REG_CONF_THR:    box_cfg.confidence_threshold <= cfg_data[THR_W-1:0];
        REG_SCALE_H:     box_cfg.scale_horizontal     <= cfg_data[SCALE_W-1:0];
        REG_SCALE_V:     box_cfg.scale_vertical       <= cfg_data[SCALE_W-1:0];
        REG_IMAGE_W:     box_cfg.image_width          <= cfg_data[PIX_W-1:0];
        REG_IMAGE_H:     box_cfg.image_height         <= cfg_data[PIX_W-1:0];
        REG_ROWS:        rows_per_frame               <= cfg_data[ROW_W-1:0];
      endcase
    end
  end

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign elem_fire = s_tvalid && advance;

  dbdf_row_accum u_row_accum (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .elem_fire      (elem_fire),
    .elem           ($signed(s_tdata)),
    .class_count    (class_count),
    .rows_per_frame (rows_per_frame),
    .rec_valid      (rec_valid),
    .rec            (rec)
  );

  dbdf_box_calc u_box_calc (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (box_cfg),
    .rec_valid (rec_valid),
    .rec       (rec),
    .out_valid (m_tvalid),
    .out_box   (out_box)
  );

  assign m_tdata = {out_box.row_number, out_box.class_index, out_box.score,
                    out_box.bottom_edge, out_box.right_edge, out_box.top_edge,
                    out_box.left_edge};

  a_score_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_box.score <= SCORE_W'(SCORE_MAX))
    else $error("score above saturation limit");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_box.right_edge >= out_box.left_edge)
              && (out_box.bottom_edge >= out_box.top_edge))
    else $error("box corners out of order");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_box.class_index < CLASS_W'(MAX_CLASSES))
    else $error("class index out of range");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result lost while stalled");

endmodule
